>>> rtl/tle_pkg.sv
// Package for the terminal line editor: field widths, result kinds and
// character codes. No dependencies; every other file of the block imports it.
package tle_pkg;

  localparam int BYTE_W      = 8;
  localparam int CHAR_W      = 7;   // stored line characters
  localparam int POS_W       = 7;   // write/read positions and erase count
  localparam int KIND_W      = 3;
  localparam int LINE_CAP_DEF = 128;

  typedef enum logic [KIND_W-1:0] {
    KIND_ECHO     = 3'd0,
    KIND_CHAR     = 3'd1,
    KIND_NOTREADY = 3'd2,
    KIND_EOF      = 3'd3,
    KIND_ERR      = 3'd4,
    KIND_ERASE    = 3'd5
  } kind_t;

  localparam logic [BYTE_W-1:0] CH_BS     = 8'h08;
  localparam logic [BYTE_W-1:0] CH_LF     = 8'h0A;
  localparam logic [BYTE_W-1:0] CH_CR     = 8'h0D;
  localparam logic [BYTE_W-1:0] CH_ESC    = 8'h1B;
  localparam logic [BYTE_W-1:0] CH_SPACE  = 8'h20;
  localparam logic [BYTE_W-1:0] CH_UPPERA = 8'h41;
  localparam logic [BYTE_W-1:0] CH_UPPERD = 8'h44;
  localparam logic [BYTE_W-1:0] CH_UPPERK = 8'h4B;
  localparam logic [BYTE_W-1:0] CH_LBRACK = 8'h5B;
  localparam logic [BYTE_W-1:0] CH_TILDE  = 8'h7E;

endpackage

>>> rtl/tle_req_if.sv
// Request channel of the terminal line editor: received bytes and reads.
// Depends on tle_pkg for field widths.
interface tle_req_if
  import tle_pkg::*;
;
  logic              valid;
  logic              ready;
  logic              req_type;
  logic [BYTE_W-1:0] rx_byte;
  logic              frame_error;
  logic              overrun;

  modport source (output valid, req_type, rx_byte, frame_error, overrun, input ready);
  modport sink   (input valid, req_type, rx_byte, frame_error, overrun, output ready);
endinterface

>>> rtl/tle_rsp_if.sv
// Result channel of the terminal line editor: echo bytes, line characters
// and status. Depends on tle_pkg for field widths.
interface tle_rsp_if
  import tle_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] out_kind;
  logic [BYTE_W-1:0] out_byte;
  logic [POS_W-1:0]  erase_count;
  logic              last;

  modport source (output valid, out_kind, out_byte, erase_count, last, input ready);
  modport sink   (input valid, out_kind, out_byte, erase_count, last, output ready);
endinterface

>>> rtl/terminal_line_editor.sv
// Terminal line editor top level: input register, single-pass edit logic,
// output burst register. Depends on tle_pkg, tle_req_if, tle_rsp_if, tle_line_store.
//
// Edits one text line from received bytes and echoes what it accepts. Each
// request transaction is held in an input register, processed in one pass,
// and its results are loaded into one output register that hands them out
// one per cycle while the receiver is ready. Requests with at most one result
// thus stream at one per clock while the receiver is ready; CR or LF loads
// CR, LF and backspace loads ESC [ D ESC [ K, which sets the rate for those
// bytes, and the next request waits in the input register meanwhile.
// A cursor-up sequence (ESC, optional '[', 'A') replaces the line with
// "[A" LF; that line is served from a small constant table instead of the
// line buffer. The line buffer has one registered read port that always
// points at the next character a reader will get, so a read request finds
// that character already registered. Buffer contents need no clearing after
// reset: a read never goes past the LF that ends the stored line.
module terminal_line_editor
  import tle_pkg::*;
#(
  parameter int LINE_CAP = LINE_CAP_DEF
) (
  input  logic       clk,
  input  logic       rst,
  tle_req_if.sink    req,
  tle_rsp_if.source  rsp
);

  localparam int AW = $clog2(LINE_CAP);
  localparam logic [POS_W-1:0] POS_LIMIT = POS_W'(LINE_CAP - 1);

  typedef enum logic [1:0] {
    ESC_NONE    = 2'd0,
    ESC_SEEN    = 2'd1,
    ESC_BRACKET = 2'd2
  } esc_t;

  typedef enum logic [1:0] {
    BURST_ONE  = 2'd0,
    BURST_CRLF = 2'd1,
    BURST_BS   = 2'd2
  } burst_t;

  // Input register
  logic              in_valid;
  logic              in_req_type;
  logic [BYTE_W-1:0] in_rx_byte;
  logic              in_frame_error;
  logic              in_overrun;

  // Edit state
  logic [POS_W-1:0]  write_pos, write_pos_next;
  logic [POS_W-1:0]  read_pos, read_pos_next;
  logic              line_ready, line_ready_next;
  esc_t              esc_phase, esc_phase_next;
  logic              canned, canned_next;   // line is the fixed cursor-up line

  // Output burst register
  logic              bvalid;
  burst_t            btype, btype_next;
  kind_t             bkind, bkind_next;
  logic [BYTE_W-1:0] bbyte, bbyte_next;
  logic [POS_W-1:0]  bcnt, bcnt_next;
  logic [2:0]        bidx;
  logic              produce;

  // Buffer ports
  logic              mem_we;
  logic [CHAR_W-1:0] mem_wdata;
  logic [CHAR_W-1:0] mem_rdata;
  logic [AW-1:0]     mem_raddr;

  logic              blast, bdone, advance;
  logic [BYTE_W-1:0] c, pc, line_char;
  logic              plain;

  // Last result of the burst in the output register.
  always_comb begin
    case (btype)
      BURST_CRLF: blast = (bidx == 3'd1);
      BURST_BS:   blast = (bidx == 3'd5);
      default:    blast = (bidx == 3'd0);
    endcase
  end

  assign bdone   = bvalid && rsp.ready && blast;
  assign advance = in_valid && (!bvalid || bdone);
  assign req.ready = !in_valid || advance;

  // Hold the request until the output register can take its results.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (req.valid && req.ready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      in_req_type    <= req.req_type;
      in_rx_byte     <= req.rx_byte;
      in_frame_error <= req.frame_error;
      in_overrun     <= req.overrun;
    end
  end

  // Character at read_pos: fixed table for the cursor-up line, else buffer.
  always_comb begin
    if (canned) begin
      case (read_pos)
        POS_W'(0): line_char = CH_LBRACK;
        POS_W'(1): line_char = CH_UPPERA;
        default:   line_char = CH_LF;
      endcase
    end else begin
      line_char = {1'b0, mem_rdata};
    end
  end

  assign c  = in_rx_byte;
  assign pc = (c == CH_CR) ? CH_LF : c;

  // Single-pass edit logic.
  always_comb begin
    write_pos_next  = write_pos;
    read_pos_next   = read_pos;
    line_ready_next = line_ready;
    esc_phase_next  = esc_phase;
    canned_next     = canned;
    mem_we          = 1'b0;
    mem_wdata       = pc[CHAR_W-1:0];
    produce         = 1'b0;
    btype_next      = BURST_ONE;
    bkind_next      = KIND_ECHO;
    bbyte_next      = '0;
    bcnt_next       = '0;
    plain           = 1'b0;

    if (in_req_type) begin
      produce = 1'b1;
      if (!line_ready) begin
        bkind_next = KIND_NOTREADY;
      end else begin
        bkind_next    = KIND_CHAR;
        bbyte_next    = line_char;
        read_pos_next = read_pos + POS_W'(1);
        if (line_char == CH_LF) begin
          // End of line: restart collecting.
          line_ready_next = 1'b0;
          write_pos_next  = '0;
          read_pos_next   = '0;
          canned_next     = 1'b0;
        end
      end
    end else if (!line_ready) begin
      if (in_frame_error || in_overrun) begin
        // Discard the line and report the receive error.
        produce        = 1'b1;
        bkind_next     = in_frame_error ? KIND_EOF : KIND_ERR;
        write_pos_next = '0;
        esc_phase_next = ESC_NONE;
      end else if (esc_phase != ESC_NONE) begin
        if (esc_phase == ESC_SEEN && c == CH_LBRACK) begin
          esc_phase_next = ESC_BRACKET;
        end else begin
          esc_phase_next = ESC_NONE;
          if (c == CH_UPPERA) begin
            // Cursor up: erase what was typed, load the fixed line.
            produce         = 1'b1;
            bkind_next      = KIND_ERASE;
            bcnt_next       = write_pos;
            write_pos_next  = POS_W'(2);
            read_pos_next   = '0;
            line_ready_next = 1'b1;
            canned_next     = 1'b1;
          end else begin
            plain = 1'b1;
          end
        end
      end else if (c == CH_BS) begin
        if (write_pos != '0) begin
          write_pos_next = write_pos - POS_W'(1);
          produce        = 1'b1;
          btype_next     = BURST_BS;
        end
      end else if (c == CH_ESC) begin
        esc_phase_next = ESC_SEEN;
      end else begin
        plain = 1'b1;
      end

      if (plain) begin
        if (pc == CH_LF) begin
          mem_we          = 1'b1;
          produce         = 1'b1;
          btype_next      = BURST_CRLF;
          line_ready_next = 1'b1;
          read_pos_next   = '0;
        end else if (pc >= CH_SPACE && pc <= CH_TILDE && write_pos < POS_LIMIT) begin
          mem_we         = 1'b1;
          produce        = 1'b1;
          bbyte_next     = pc;
          write_pos_next = write_pos + POS_W'(1);
        end
      end
    end
  end

  // Keep the read port on the character the next read request will get.
  assign mem_raddr = advance ? read_pos_next[AW-1:0] : read_pos[AW-1:0];

  tle_line_store #(
    .DEPTH (LINE_CAP),
    .AW    (AW)
  ) u_store (
    .clk   (clk),
    .we    (advance && mem_we),
    .waddr (write_pos[AW-1:0]),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // Edit state advances once per processed request.
  always_ff @(posedge clk) begin
    if (rst) begin
      write_pos  <= '0;
      read_pos   <= '0;
      line_ready <= 1'b0;
      esc_phase  <= ESC_NONE;
      canned     <= 1'b0;
    end else if (advance) begin
      write_pos  <= write_pos_next;
      read_pos   <= read_pos_next;
      line_ready <= line_ready_next;
      esc_phase  <= esc_phase_next;
      canned     <= canned_next;
    end
  end

  // Output register: load a burst, then step through its results.
  always_ff @(posedge clk) begin
    if (rst) begin
      bvalid <= 1'b0;
      bidx   <= '0;
    end else if (advance) begin
      bvalid <= produce;
      bidx   <= '0;
    end else if (bdone) begin
      bvalid <= 1'b0;
    end else if (bvalid && rsp.ready) begin
      bidx <= bidx + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      btype <= btype_next;
      bkind <= bkind_next;
      bbyte <= bbyte_next;
      bcnt  <= bcnt_next;
    end
  end

  // Expand the burst into the current result.
  always_comb begin
    rsp.out_kind    = KIND_W'(KIND_ECHO);
    rsp.out_byte    = '0;
    rsp.erase_count = '0;
    case (btype)
      BURST_CRLF: begin
        rsp.out_byte = (bidx == 3'd0) ? CH_CR : CH_LF;
      end
      BURST_BS: begin
        case (bidx)
          3'd0, 3'd3: rsp.out_byte = CH_ESC;
          3'd1, 3'd4: rsp.out_byte = CH_LBRACK;
          3'd2:       rsp.out_byte = CH_UPPERD;
          default:    rsp.out_byte = CH_UPPERK;
        endcase
      end
      default: begin
        rsp.out_kind    = bkind;
        rsp.out_byte    = bbyte;
        rsp.erase_count = bcnt;
      end
    endcase
  end

  assign rsp.valid = bvalid;
  assign rsp.last  = blast;

endmodule

>>> rtl/tle_line_store.sv
// Line buffer of the terminal line editor: one write port, one registered
// read port with write-first forwarding. Depends on tle_pkg.
module tle_line_store
  import tle_pkg::*;
#(
  parameter int DEPTH = LINE_CAP_DEF,
  parameter int AW    = $clog2(LINE_CAP_DEF)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [AW-1:0]     waddr,
  input  logic [CHAR_W-1:0] wdata,
  input  logic [AW-1:0]     raddr,
  output logic [CHAR_W-1:0] rdata
);

  logic [CHAR_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Return the value being written when both ports hit the same entry.
  always_ff @(posedge clk) begin
    if (we && (waddr == raddr)) begin
      rdata <= wdata;
    end else begin
      rdata <= mem[raddr];
    end
  end

endmodule
